FILE: hw/rtl/kdm_pkg.sv
// ----------------------------------------------------------------------------
// kdm_pkg
// Shared types and constants of the key debounce / mouse report block.
// ----------------------------------------------------------------------------
package kdm_pkg;

  localparam int unsigned DEBOUNCE_LEN = 16;
  localparam int unsigned NUM_KEYS     = 6;

  // key positions in raw_keys
  localparam int unsigned K_CLICK  = 0;
  localparam int unsigned K_LEFT   = 1;
  localparam int unsigned K_UP     = 2;
  localparam int unsigned K_DOWN   = 3;
  localparam int unsigned K_RIGHT  = 4;
  localparam int unsigned K_SECOND = 5;

  // event codes
  localparam logic [7:0] EV_NONE    = 8'h00;
  localparam logic [7:0] EV_LEFT    = 8'hfe;
  localparam logic [7:0] EV_MIDDLE  = 8'hfd;
  localparam logic [7:0] EV_RIGHT   = 8'hfb;
  localparam logic [7:0] EV_RELEASE = 8'h55;
  localparam logic [7:0] EV_X_NEG   = 8'hef;
  localparam logic [7:0] EV_X_POS   = 8'hdf;
  localparam logic [7:0] EV_Y_NEG   = 8'hbf;
  localparam logic [7:0] EV_Y_POS   = 8'h7f;

  // register indexes
  localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS      = 2'd1;
  localparam logic [1:0] REG_MOVE_STEP       = 2'd2;

  localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd20;
  localparam logic [15:0] RST_LONG_PRESS      = 16'd700;
  localparam logic [6:0]  RST_MOVE_STEP       = 7'd4;

  localparam logic [15:0] HOLD_MAX = 16'hffff;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_TIMING = 3'b010,
    PH_LONG   = 3'b100
  } hold_phase_e;

  typedef struct packed {
    logic [15:0] repeat_interval;
    logic [15:0] long_press_ticks;
    logic [6:0]  move_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        button_bits;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
  } report_t;

  function automatic report_t decode_event(logic [7:0] code, logic [6:0] step);
    report_t    r;
    logic [7:0] pos;
    logic [7:0] neg;
    pos = {1'b0, step};
    neg = 8'(~pos + 8'd1);
    r   = '0;
    case (code)
      EV_LEFT:   r.button_bits = 3'b001;
      EV_MIDDLE: r.button_bits = 3'b100;
      EV_RIGHT:  r.button_bits = 3'b010;
      EV_X_NEG:  r.move_x      = neg;
      EV_X_POS:  r.move_x      = pos;
      EV_Y_NEG:  r.move_y      = neg;
      EV_Y_POS:  r.move_y      = pos;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/key_debounce_mouse_report_core.sv
// ----------------------------------------------------------------------------
// key_debounce_mouse_report_core
// A report passes the input register, then the result register, on its way
// out. Throughput: one tick item per cycle; the input register holds only
// while a report waits behind a stalled output.
// Reset: histories and key levels all released, hold idle, nothing pending,
// registers at 20 / 700 / 4. No clearing pass.
// ----------------------------------------------------------------------------
module key_debounce_mouse_report_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [5:0]        raw_keys_i,
  input  logic              link_configured_i,
  input  logic              link_busy_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        button_bits_o,
  output logic signed [7:0] move_x_o,
  output logic signed [7:0] move_y_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import kdm_pkg::*;

  logic                s1_valid_q, s1_valid_d;
  logic [NUM_KEYS-1:0] s1_keys_q;
  logic                s1_cfgd_q;
  logic                s1_busy_q;
  logic                accept;
  logic                advance;
  logic                res_valid;
  logic                out_ready;
  report_t             res;
  report_t             out_data;
  cfg_t                cfg;

  kdm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // item in stage 1 retires unless it has a report and the output is blocked
  assign advance    = s1_valid_q && (!res_valid || out_ready);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)       s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_keys_q <= raw_keys_i;
      s1_cfgd_q <= link_configured_i;
      s1_busy_q <= link_busy_i;
    end
  end

  kdm_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .raw_keys_i        (s1_keys_q),
    .link_configured_i (s1_cfgd_q),
    .link_busy_i       (s1_busy_q),
    .cfg_i             (cfg),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  kdm_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .data_i  (res),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign button_bits_o = out_data.button_bits;
  assign move_x_o      = out_data.move_x;
  assign move_y_o      = out_data.move_y;

endmodule

FILE: hw/rtl/kdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdm_cfg_regs
// APB-style register file: repeat interval, long press threshold, move step.
// ----------------------------------------------------------------------------
module kdm_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output kdm_pkg::cfg_t  cfg_o
);
  import kdm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_REPEAT_INTERVAL: cfg_d.repeat_interval  = pwdata[15:0];
        REG_LONG_PRESS:      cfg_d.long_press_ticks = pwdata[15:0];
        REG_MOVE_STEP:       cfg_d.move_step        = pwdata[6:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REPEAT_INTERVAL: prdata = {16'd0, cfg_q.repeat_interval};
      REG_LONG_PRESS:      prdata = {16'd0, cfg_q.long_press_ticks};
      REG_MOVE_STEP:       prdata = {25'd0, cfg_q.move_step};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_interval  <= RST_REPEAT_INTERVAL;
      cfg_q.long_press_ticks <= RST_LONG_PRESS;
      cfg_q.move_step        <= RST_MOVE_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/kdm_engine.sv
// ----------------------------------------------------------------------------
// kdm_engine
// Per-tick debounce, hold timing, event queueing and send decision.
// ----------------------------------------------------------------------------
module kdm_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [kdm_pkg::NUM_KEYS-1:0]    raw_keys_i,
  input  logic                            link_configured_i,
  input  logic                            link_busy_i,
  input  kdm_pkg::cfg_t                   cfg_i,
  output logic                            res_valid_o,
  output kdm_pkg::report_t                res_o
);
  import kdm_pkg::*;

  localparam logic [DEBOUNCE_LEN-1:0] HIST_ONES = '1;

  logic [DEBOUNCE_LEN-1:0] hist_q [NUM_KEYS];
  logic [DEBOUNCE_LEN-1:0] hist_d [NUM_KEYS];
  logic [NUM_KEYS-1:0]     stable_q, stable_d;
  logic [NUM_KEYS-1:0]     prev_q;
  hold_phase_e             phase_q, phase_d;
  logic [15:0]             hold_q, hold_d;
  logic [7:0]              pend_q, pend_d;
  logic                    pv_q, pv_d;

  logic                    ok;
  logic                    sent;
  logic [7:0]              sent_code;

  assign ok = link_configured_i && !link_busy_i;

  always_comb begin
    hold_d    = hold_q;
    phase_d   = phase_q;
    pend_d    = pend_q;
    pv_d      = pv_q;
    sent      = 1'b0;
    sent_code = EV_NONE;

    if (phase_d != PH_IDLE && hold_d != HOLD_MAX) hold_d = hold_d + 16'd1;
    if (phase_d == PH_TIMING && hold_d > cfg_i.long_press_ticks) phase_d = PH_LONG;

    for (int i = 0; i < NUM_KEYS; i++) begin
      hist_d[i] = {hist_q[i][DEBOUNCE_LEN-2:0], raw_keys_i[i]};
      if (hist_d[i] == '0)             stable_d[i] = 1'b0;
      else if (hist_d[i] == HIST_ONES) stable_d[i] = 1'b1;
      else                             stable_d[i] = stable_q[i];
    end

    // auto-repeat, priority up, left, down, right
    if (phase_d == PH_LONG && hold_d >= cfg_i.repeat_interval) begin
      if (!stable_d[K_UP]) begin
        pend_d = EV_Y_NEG; pv_d = 1'b1; hold_d = '0;
      end else if (!stable_d[K_LEFT]) begin
        pend_d = EV_X_NEG; pv_d = 1'b1; hold_d = '0;
      end else if (!stable_d[K_DOWN]) begin
        pend_d = EV_Y_POS; pv_d = 1'b1; hold_d = '0;
      end else if (!stable_d[K_RIGHT]) begin
        pend_d = EV_X_POS; pv_d = 1'b1; hold_d = '0;
      end
    end

    // click release: left press goes out at once if it can, release follows
    if (stable_d[K_CLICK] && !prev_q[K_CLICK]) begin
      if (ok) begin
        sent = 1'b1; sent_code = EV_LEFT;
      end
      pend_d = EV_RELEASE; pv_d = 1'b1;
    end

    if (stable_d[K_SECOND] != prev_q[K_SECOND]) begin
      pend_d = prev_q[K_SECOND] ? EV_LEFT : EV_RELEASE;
      pv_d   = 1'b1;
      if (ok && !sent) begin
        sent = 1'b1; sent_code = pend_d; pv_d = 1'b0;
      end
    end

    // direction edges in order up, down, right, left; last queued wins
    if (stable_d[K_UP] != prev_q[K_UP]) begin
      if (!prev_q[K_UP]) begin
        pend_d = EV_Y_NEG; pv_d = 1'b1; phase_d = PH_IDLE; hold_d = '0;
      end else phase_d = PH_TIMING;
    end
    if (stable_d[K_DOWN] != prev_q[K_DOWN]) begin
      if (!prev_q[K_DOWN]) begin
        pend_d = EV_Y_POS; pv_d = 1'b1; phase_d = PH_IDLE; hold_d = '0;
      end else phase_d = PH_TIMING;
    end
    if (stable_d[K_RIGHT] != prev_q[K_RIGHT]) begin
      if (!prev_q[K_RIGHT]) begin
        pend_d = EV_X_POS; pv_d = 1'b1; phase_d = PH_IDLE; hold_d = '0;
      end else phase_d = PH_TIMING;
    end
    if (stable_d[K_LEFT] != prev_q[K_LEFT]) begin
      if (!prev_q[K_LEFT]) begin
        pend_d = EV_X_NEG; pv_d = 1'b1; phase_d = PH_IDLE; hold_d = '0;
      end else phase_d = PH_TIMING;
    end

    if (ok && !sent && pv_d) begin
      sent = 1'b1; sent_code = pend_d; pv_d = 1'b0;
    end
  end

  assign res_valid_o = sent;
  assign res_o       = decode_event(sent_code, cfg_i.move_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) hist_q[i] <= HIST_ONES;
      stable_q <= '1;
      prev_q   <= '1;
      phase_q  <= PH_IDLE;
      hold_q   <= '0;
      pend_q   <= EV_NONE;
      pv_q     <= 1'b0;
    end else if (step_i) begin
      for (int i = 0; i < NUM_KEYS; i++) hist_q[i] <= hist_d[i];
      stable_q <= stable_d;
      prev_q   <= stable_d;
      phase_q  <= phase_d;
      hold_q   <= hold_d;
      pend_q   <= pend_d;
      pv_q     <= pv_d;
    end
  end

endmodule

FILE: hw/rtl/kdm_out_reg.sv
// ----------------------------------------------------------------------------
// kdm_out_reg
// Result register holding one report item until the receiver takes it.
// ----------------------------------------------------------------------------
module kdm_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  kdm_pkg::report_t  data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output kdm_pkg::report_t  data_o
);
  import kdm_pkg::*;

  logic    valid_q, valid_d;
  report_t data_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) valid_d = load_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) data_q <= data_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: dv/key_debounce_mouse_report_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_debounce_mouse_report_core_test
// Self-checking bench for the key debounce / mouse report core. Tick items
// carry raw key levels and link status. A local tick-by-tick model of the
// debounce, hold timing and report logic predicts each report, and a monitor
// compares what leaves the core field by field. The APB registers are
// written between phases and read back.
// ----------------------------------------------------------------------------
module key_debounce_mouse_report_core_test;
  import kdm_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;   // no register behind this index
  localparam int unsigned DRAIN_SPIN = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [5:0]        raw_keys_i;
  logic              link_configured_i;
  logic              link_busy_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        button_bits_o;
  logic signed [7:0] move_x_o;
  logic signed [7:0] move_y_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  key_debounce_mouse_report_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_keys_i        (raw_keys_i),
    .link_configured_i (link_configured_i),
    .link_busy_i       (link_busy_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .button_bits_o     (button_bits_o),
    .move_x_o          (move_x_o),
    .move_y_o          (move_y_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // key / report model
  // --------------------------------------------------------------------------
  cfg_t                    cfg_m;
  logic [DEBOUNCE_LEN-1:0] hist_m [NUM_KEYS];
  logic [NUM_KEYS-1:0]     level_m;
  logic [NUM_KEYS-1:0]     last_level_m;
  hold_phase_e             phase_m;
  logic [15:0]             hold_m;
  logic [7:0]              pend_code_m;
  bit                      pend_m;
  bit                      link_taken;     // a report already left this tick
  report_t                 reports_due [$];

  int unsigned err_cnt      = 0;
  int unsigned items_sent   = 0;
  int unsigned reports_seen = 0;
  int unsigned reg_writes   = 0;
  bit          tx_jitter    = 1'b1;
  bit          rx_jitter    = 1'b1;
  int unsigned rx_hold_left = 0;
  int unsigned rx_burst_left = 0;
  bit          rx_burst_stall = 1'b0;

  function automatic void clear_key_model();
    cfg_m.repeat_interval  = RST_REPEAT_INTERVAL;
    cfg_m.long_press_ticks = RST_LONG_PRESS;
    cfg_m.move_step        = RST_MOVE_STEP;
    for (int k = 0; k < NUM_KEYS; k++) hist_m[k] = '1;
    level_m      = '1;
    last_level_m = '1;
    phase_m      = PH_IDLE;
    hold_m       = '0;
    pend_code_m  = EV_NONE;
    pend_m       = 1'b0;
  endfunction

  function automatic report_t report_for(logic [7:0] code);
    report_t    r;
    logic [7:0] mag;
    mag = {1'b0, cfg_m.move_step};
    r   = '0;
    case (code)
      EV_LEFT:   r.button_bits = 3'b001;
      EV_RIGHT:  r.button_bits = 3'b010;
      EV_MIDDLE: r.button_bits = 3'b100;
      EV_X_NEG:  r.move_x = 8'd0 - mag;
      EV_X_POS:  r.move_x = mag;
      EV_Y_NEG:  r.move_y = 8'd0 - mag;
      EV_Y_POS:  r.move_y = mag;
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic void post_event(logic [7:0] code);
    pend_code_m = code;
    pend_m      = 1'b1;
  endfunction

  function automatic void try_report(bit configured);
    if (!configured || link_taken || !pend_m) return;
    pend_m     = 1'b0;
    link_taken = 1'b1;
    reports_due.push_back(report_for(pend_code_m));
  endfunction

  function automatic void direction_edge(int unsigned k, logic [7:0] code);
    if (level_m[k] == last_level_m[k]) return;
    if (last_level_m[k] == 1'b0) begin
      post_event(code);
      phase_m = PH_IDLE;
      hold_m  = '0;
    end else begin
      phase_m = PH_TIMING;
    end
    last_level_m[k] = level_m[k];
  endfunction

  function automatic void debounce_and_report(logic [5:0] keys, bit configured, bit busy);
    link_taken = busy;
    if (phase_m != PH_IDLE && hold_m != HOLD_MAX) hold_m = hold_m + 16'd1;
    if (phase_m == PH_TIMING && hold_m > cfg_m.long_press_ticks) phase_m = PH_LONG;

    for (int k = 0; k < NUM_KEYS; k++) begin
      hist_m[k] = {hist_m[k][DEBOUNCE_LEN-2:0], keys[k]};
      if (hist_m[k] == '0) level_m[k] = 1'b0;
      else if (&hist_m[k]) level_m[k] = 1'b1;
    end

    // auto-repeat priority: up, left, down, right
    if (phase_m == PH_LONG && hold_m >= cfg_m.repeat_interval) begin
      if (!level_m[K_UP]) begin
        post_event(EV_Y_NEG); hold_m = '0;
      end else if (!level_m[K_LEFT]) begin
        post_event(EV_X_NEG); hold_m = '0;
      end else if (!level_m[K_DOWN]) begin
        post_event(EV_Y_POS); hold_m = '0;
      end else if (!level_m[K_RIGHT]) begin
        post_event(EV_X_POS); hold_m = '0;
      end
    end

    // click acts on release only: left press, then all released
    if (level_m[K_CLICK] != last_level_m[K_CLICK]) begin
      if (last_level_m[K_CLICK] == 1'b0) begin
        post_event(EV_LEFT);
        try_report(configured);
        post_event(EV_RELEASE);
        try_report(configured);
      end
      last_level_m[K_CLICK] = level_m[K_CLICK];
    end

    if (level_m[K_SECOND] != last_level_m[K_SECOND]) begin
      post_event(last_level_m[K_SECOND] == 1'b0 ? EV_RELEASE : EV_LEFT);
      try_report(configured);
      last_level_m[K_SECOND] = level_m[K_SECOND];
    end

    direction_edge(K_UP, EV_Y_NEG);
    direction_edge(K_DOWN, EV_Y_POS);
    direction_edge(K_RIGHT, EV_X_POS);
    direction_edge(K_LEFT, EV_X_NEG);

    try_report(configured);
  endfunction

  // --------------------------------------------------------------------------
  // report monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_reports
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_seen++;
      if (reports_due.size() == 0) begin
        $error("unexpected report: buttons %0h x %0d y %0d",
               button_bits_o, move_x_o, move_y_o);
        err_cnt++;
      end else begin
        want = reports_due.pop_front();
        if (button_bits_o !== want.button_bits) begin
          $error("button_bits: expected %0h, got %0h", want.button_bits, button_bits_o);
          err_cnt++;
        end
        if (move_x_o !== want.move_x) begin
          $error("move_x: expected %0d, got %0d", want.move_x, move_x_o);
          err_cnt++;
        end
        if (move_y_o !== want.move_y) begin
          $error("move_y: expected %0d, got %0d", want.move_y, move_y_o);
          err_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver stall: random bursts, plus a long hold-off on request
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else if (!rx_jitter) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_burst_left == 0) begin
        rx_burst_stall = !rx_burst_stall;
        if (rx_burst_stall) rx_burst_left = 1 + pick_gap();
        else if ($urandom_range(9) == 0) rx_burst_left = $urandom_range(50, 200);
        else rx_burst_left = $urandom_range(1, 12);
      end
      rx_burst_left--;
      out_stall_i <= rx_burst_stall;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [5:0] keys, input bit configured, input bit busy);
    int unsigned gap;
    gap = tx_jitter ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_keys_i        <= keys;
    link_configured_i <= configured;
    link_busy_i       <= busy;
    do @(posedge clk_i); while (in_stall_o);
    debounce_and_report(keys, configured, busy);
    items_sent++;
  endtask

  task automatic hold_keys(input logic [5:0] keys, input int unsigned n,
                           input bit configured, input bit busy);
    repeat (n) send_tick(keys, configured, busy);
  endtask

  function automatic logic [5:0] key_down(int unsigned k);
    return ~(6'b1 << k);
  endfunction

  // sender idles until every predicted report is in, plus the core's latency
  task automatic wait_drained();
    int unsigned spin;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    spin = 0;
    while (reports_due.size() != 0 && spin < DRAIN_SPIN) begin
      @(posedge clk_i);
      spin++;
    end
    if (reports_due.size() != 0) begin
      $error("%0d expected reports never arrived", reports_due.size());
      err_cnt++;
      reports_due.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [3:0] addr, output logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic compare_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    apb_read({idx, 2'b00}, got);
    if (got !== want) begin
      $error("register %0d: expected %0h, got %0h", idx, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_regs();
    compare_reg(REG_REPEAT_INTERVAL, 32'(cfg_m.repeat_interval));
    compare_reg(REG_LONG_PRESS, 32'(cfg_m.long_press_ticks));
    compare_reg(REG_MOVE_STEP, 32'(cfg_m.move_step));
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    apb_write({idx, 2'b00}, val);
    reg_writes++;
    case (idx)
      REG_REPEAT_INTERVAL: cfg_m.repeat_interval  = val[15:0];
      REG_LONG_PRESS:      cfg_m.long_press_ticks = val[15:0];
      REG_MOVE_STEP:       cfg_m.move_step        = val[6:0];
      default: ;
    endcase
    check_regs();
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_registers();
    check_regs();
    set_reg(REG_REPEAT_INTERVAL, 32'h0000_ffff);
    set_reg(REG_LONG_PRESS, 32'h0000_0000);
    set_reg(REG_MOVE_STEP, 32'h0000_007f);
    set_reg(REG_UNUSED, 32'h0000_1234);                   // must be ignored
    set_reg(REG_MOVE_STEP, {8'($urandom_range(1, 255)), 17'h0, 7'h01});  // high bits dropped
    set_reg(REG_REPEAT_INTERVAL, 32'(RST_REPEAT_INTERVAL));
    set_reg(REG_LONG_PRESS, 32'(RST_LONG_PRESS));
    set_reg(REG_MOVE_STEP, 32'(RST_MOVE_STEP));
  endtask

  task automatic test_each_key();
    for (int unsigned k = 0; k < NUM_KEYS; k++) begin
      hold_keys(key_down(k), DEBOUNCE_LEN, 1'b1, 1'b0);
      hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    end
    // everything pressed and released together
    hold_keys('0, DEBOUNCE_LEN, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    // link down: event waits until the link comes up
    hold_keys(key_down(K_SECOND), DEBOUNCE_LEN, 1'b0, 1'b0);
    hold_keys('1, DEBOUNCE_LEN, 1'b0, 1'b0);
    hold_keys('1, 3, 1'b1, 1'b0);
    // link busy over the click release
    hold_keys(key_down(K_CLICK), DEBOUNCE_LEN, 1'b1, 1'b1);
    hold_keys('1, DEBOUNCE_LEN, 1'b1, 1'b1);
    hold_keys('1, 2, 1'b1, 1'b0);
    // a short bounce must not move the stable level
    hold_keys(key_down(K_UP), DEBOUNCE_LEN - 1, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_auto_repeat();
    set_reg(REG_LONG_PRESS, 32'd5);
    set_reg(REG_REPEAT_INTERVAL, 32'd3);
    for (int unsigned k = K_LEFT; k <= K_RIGHT; k++) begin
      hold_keys(key_down(k), 40, 1'b1, 1'b0);
      hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    end
    // two directions held: priority picks one
    hold_keys(key_down(K_LEFT) & key_down(K_DOWN), 40, 1'b1, 1'b0);
    hold_keys(key_down(K_RIGHT) & key_down(K_DOWN), 40, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    wait_drained();

    // long press at zero, repeat every tick, zero step
    set_reg(REG_LONG_PRESS, 32'd0);
    set_reg(REG_REPEAT_INTERVAL, 32'd0);
    set_reg(REG_MOVE_STEP, 32'd0);
    hold_keys(key_down(K_UP), 24, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    wait_drained();
    set_reg(REG_MOVE_STEP, 32'd127);
    hold_keys(key_down(K_RIGHT), 24, 1'b1, 1'b0);
    hold_keys(key_down(K_RIGHT), 8, 1'b1, 1'b1);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    wait_drained();
    set_reg(REG_MOVE_STEP, 32'd1);
    hold_keys(key_down(K_LEFT), 24, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_reg(REG_LONG_PRESS, 32'd4);
    set_reg(REG_REPEAT_INTERVAL, 32'd1);
    rx_hold_left = 300;
    hold_keys(key_down(K_CLICK), DEBOUNCE_LEN, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN, 1'b1, 1'b0);
    hold_keys(key_down(K_DOWN), 30, 1'b1, 1'b0);
    hold_keys(key_down(K_SECOND), DEBOUNCE_LEN + 4, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    // sender waits for every report before going on
    wait_drained();
    hold_keys(key_down(K_RIGHT), 30, 1'b1, 1'b0);
    hold_keys('1, DEBOUNCE_LEN + 1, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [5:0]  keys;
    logic [5:0]  drive;
    logic [15:0] rep;
    logic [15:0] lp;
    logic [6:0]  step;
    int unsigned span;
    int unsigned r;
    int unsigned first;
    keys = '1;
    for (int unsigned setting = 0; setting < 5; setting++) begin
      wait_drained();
      case (setting)
        0: begin
          rep = 16'($urandom_range(1, 8)); lp = 16'($urandom_range(0, 40));
          step = 7'($urandom_range(1, 127));
        end
        1: begin rep = 16'd1; lp = 16'd0; step = 7'd1; end
        2: begin rep = 16'hffff; lp = 16'hffff; step = 7'd127; end
        3: begin
          rep = 16'($urandom_range(1, 12)); lp = 16'($urandom_range(0, 60));
          step = 7'($urandom_range(64, 127));
        end
        default: begin
          rep = 16'($urandom_range(1, 30)); lp = 16'($urandom_range(20, 90));
          step = 7'($urandom_range(1, 63));
        end
      endcase
      set_reg(REG_REPEAT_INTERVAL, 32'(rep));
      set_reg(REG_LONG_PRESS, 32'(lp));
      set_reg(REG_MOVE_STEP, 32'(step));
      first = items_sent;
      while (items_sent - first < 250 ||
             (setting == 4 && reports_seen + reports_due.size() < 60 &&
              items_sent - first < 6000)) begin
        case ($urandom_range(9))
          0:       keys = 6'($urandom);
          1, 2, 3, 4, 5: keys ^= 6'(1 << $urandom_range(5));
          6, 7:    keys = '1;
          default: keys ^= 6'(1 << $urandom_range(5)) | 6'(1 << $urandom_range(5));
        endcase
        r = $urandom_range(19);
        if (r < 13) span = $urandom_range(DEBOUNCE_LEN, 30);
        else if (r < 17) span = $urandom_range(1, DEBOUNCE_LEN - 1);
        else span = $urandom_range(31, 120);
        repeat (span) begin
          drive = keys;
          if ($urandom_range(19) == 0) drive ^= 6'(1 << $urandom_range(5));  // bounce
          send_tick(drive, $urandom_range(15) != 0, $urandom_range(4) == 0);
        end
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    raw_keys_i        = '1;
    link_configured_i = 1'b0;
    link_busy_i       = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    clear_key_model();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_registers();
    test_each_key();
    test_auto_repeat();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    $display("covered %0d tick items incl. auto-repeat, link waits and long output stalls",
             items_sent);
    $display("checked %0d reports across %0d register writes", reports_seen, reg_writes);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/kdm_pkg.sv
hw/rtl/kdm_cfg_regs.sv
hw/rtl/kdm_engine.sv
hw/rtl/kdm_out_reg.sv
hw/rtl/key_debounce_mouse_report_core.sv
dv/key_debounce_mouse_report_core_test.sv
